>>> src/nrld_pkg.sv
// ----------------------------------------------------------------------------
// nrld_pkg: shared types and constants of the run-list decoder
// Result kinds, register indexes, the queue entry type and the offset
// sign extension used by the byte parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nrld_pkg;

  typedef enum logic [1:0] {
    KIND_RUN = 2'd0,
    KIND_END = 2'd1,
    KIND_BAD = 2'd2
  } result_kind_t;

  localparam logic CFG_HIDDEN_SECTORS      = 1'b0;
  localparam logic CFG_SECTORS_PER_CLUSTER = 1'b1;

  localparam logic [7:0] SPC_RESET = 8'd8;

  // Largest length or offset field in bytes.
  localparam logic [3:0] MAX_FIELD_BYTES = 4'd4;

  typedef struct packed {
    result_kind_t kind;
    logic [31:0]  run_clusters;
    logic [63:0]  start_cluster;
  } job_t;

  // Sign-extend an offset of one to four bytes to 64 bits.
  function automatic logic [63:0] sign_extend(input logic [31:0] w,
                                              input logic [2:0]  nbytes);
    logic [63:0] v;
    case (nbytes)
      3'd1:    v = {{56{w[7]}}, w[7:0]};
      3'd2:    v = {{48{w[15]}}, w[15:0]};
      3'd3:    v = {{40{w[23]}}, w[23:0]};
      default: v = {{32{w[31]}}, w};
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/nrld_ifs.sv
// ----------------------------------------------------------------------------
// nrld_ifs: channel interfaces of the run-list decoder
// One interface for the incoming list bytes and one for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface nrld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_byte;
  logic       list_start;

  modport source (output valid, output run_byte, output list_start, input ready);
  modport sink   (input valid, input run_byte, input list_start, output ready);
  modport monitor (input valid, input ready, input run_byte, input list_start);
endinterface

interface nrld_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] run_clusters;
  logic [63:0] start_cluster;
  logic [63:0] start_sector;
  logic        list_done;

  modport source (output valid, output result_kind, output run_clusters,
                  output start_cluster, output start_sector, output list_done,
                  input ready);
  modport sink   (input valid, input result_kind, input run_clusters,
                  input start_cluster, input start_sector, input list_done,
                  output ready);
  modport monitor (input valid, input ready, input result_kind, input run_clusters,
                   input start_cluster, input start_sector, input list_done);
endinterface

`default_nettype wire

>>> src/nrld_front.sv
// ----------------------------------------------------------------------------
// nrld_front: byte parser of the run-list decoder
// Takes one byte a cycle while the job queue has room, decodes headers,
// gathers the length and offset fields, keeps the running cluster number
// and requests a job for every finished run, end of list or bad header.
// ----------------------------------------------------------------------------
`default_nettype none

module nrld_front (
  input  wire logic         clk,
  input  wire logic         rst,
  nrld_byte_if.sink         list_bytes,
  output nrld_pkg::job_t    job,
  output logic              job_push,
  input  wire logic         job_space
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  len_count, len_count_next;
  logic [2:0]  off_count, off_count_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [31:0] len_acc, len_acc_next;
  logic [31:0] off_acc, off_acc_next;
  logic [63:0] cluster_sum, cluster_sum_next;

  logic        accept;
  phase_t      ph_eff;
  logic [63:0] cs_eff;
  logic [3:0]  lo_nib, hi_nib;
  logic        hdr_bad;
  logic [31:0] byte_word;
  logic [2:0]  idx_inc;
  logic [31:0] off_full;
  logic [63:0] cs_new;

  assign list_bytes.ready = job_space;
  assign accept = list_bytes.valid && list_bytes.ready;

  assign ph_eff    = list_bytes.list_start ? PH_HEADER : phase;
  assign cs_eff    = list_bytes.list_start ? 64'd0 : cluster_sum;
  assign lo_nib    = list_bytes.run_byte[3:0];
  assign hi_nib    = list_bytes.run_byte[7:4];
  assign hdr_bad   = (lo_nib == 4'd0) || (lo_nib > nrld_pkg::MAX_FIELD_BYTES) ||
                     (hi_nib == 4'd0) || (hi_nib > nrld_pkg::MAX_FIELD_BYTES);
  assign byte_word = {24'd0, list_bytes.run_byte} << {byte_idx, 3'b000};
  assign idx_inc   = {1'b0, byte_idx} + 3'd1;
  assign off_full  = off_acc | byte_word;
  assign cs_new    = cs_eff + nrld_pkg::sign_extend(off_full, off_count);

  always_comb begin
    phase_next         = phase;
    len_count_next     = len_count;
    off_count_next     = off_count;
    byte_idx_next      = byte_idx;
    len_acc_next       = len_acc;
    off_acc_next       = off_acc;
    cluster_sum_next   = cs_eff;
    job_push           = 1'b0;
    job.kind           = nrld_pkg::KIND_RUN;
    job.run_clusters   = 32'd0;
    job.start_cluster  = 64'd0;
    unique case (ph_eff)
      PH_HEADER: begin
        if (list_bytes.run_byte == 8'd0) begin
          phase_next = PH_IDLE;
          job_push   = accept;
          job.kind   = nrld_pkg::KIND_END;
        end else if (hdr_bad) begin
          phase_next = PH_IDLE;
          job_push   = accept;
          job.kind   = nrld_pkg::KIND_BAD;
        end else begin
          len_count_next = lo_nib[2:0];
          off_count_next = hi_nib[2:0];
          byte_idx_next  = 2'd0;
          len_acc_next   = 32'd0;
          off_acc_next   = 32'd0;
          phase_next     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc_next  = len_acc | byte_word;
        byte_idx_next = idx_inc[1:0];
        if (idx_inc >= len_count) begin
          byte_idx_next = 2'd0;
          phase_next    = PH_OFFSET;
        end
      end
      PH_OFFSET: begin
        off_acc_next  = off_full;
        byte_idx_next = idx_inc[1:0];
        if (idx_inc >= off_count) begin
          byte_idx_next     = 2'd0;
          phase_next        = PH_HEADER;
          cluster_sum_next  = cs_new;
          job_push          = accept;
          job.kind          = nrld_pkg::KIND_RUN;
          job.run_clusters  = len_acc;
          job.start_cluster = cs_new;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      len_count   <= 3'd0;
      off_count   <= 3'd0;
      byte_idx    <= 2'd0;
      len_acc     <= 32'd0;
      off_acc     <= 32'd0;
      cluster_sum <= 64'd0;
    end else if (accept) begin
      phase       <= phase_next;
      len_count   <= len_count_next;
      off_count   <= off_count_next;
      byte_idx    <= byte_idx_next;
      len_acc     <= len_acc_next;
      off_acc     <= off_acc_next;
      cluster_sum <= cluster_sum_next;
    end
  end

endmodule

`default_nettype wire

>>> src/nrld_queue.sv
// ----------------------------------------------------------------------------
// nrld_queue: job queue between parser and address stage
// A small first-in first-out store so that the parser and the result side
// can stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module nrld_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire nrld_pkg::job_t  push_job,
  output logic                 space,
  output logic                 pop_valid,
  output nrld_pkg::job_t       pop_job,
  input  wire logic            pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  nrld_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign space     = (count != FULL_CNT);
  assign pop_valid = (count != '0);
  assign pop_job   = entries[rd_ptr];
  assign do_push   = push && space;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> src/nrld_back.sv
// ----------------------------------------------------------------------------
// nrld_back: sector address stage of the run-list decoder
// Multiplies the start cluster by the sectors per cluster, adds the hidden
// sectors and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module nrld_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           job_valid,
  input  wire nrld_pkg::job_t job,
  output logic                job_ready,
  input  wire logic [31:0]    hidden_sectors,
  input  wire logic [7:0]     sectors_per_cluster,
  nrld_result_if.source       results
);

  logic           prod_valid;
  nrld_pkg::job_t prod_job;
  logic [63:0]    prod;
  logic [71:0]    prod_full;
  logic           out_adv;
  logic           prod_adv;

  assign out_adv   = !results.valid || results.ready;
  assign prod_adv  = !prod_valid || out_adv;
  assign job_ready = prod_adv;
  assign prod_full = job.start_cluster * sectors_per_cluster;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_adv) begin
      prod_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_adv && job_valid) begin
      prod_job <= job;
      prod     <= prod_full[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_adv) begin
      results.valid <= prod_valid;
    end
  end

  // End and error results carry zero in every address field.
  always_ff @(posedge clk) begin
    if (out_adv && prod_valid) begin
      results.result_kind   <= prod_job.kind;
      results.run_clusters  <= prod_job.run_clusters;
      results.start_cluster <= prod_job.start_cluster;
      results.list_done     <= (prod_job.kind != nrld_pkg::KIND_RUN);
      if (prod_job.kind == nrld_pkg::KIND_RUN) begin
        results.start_sector <= prod + {32'd0, hidden_sectors};
      end else begin
        results.start_sector <= 64'd0;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/ntfs_runlist_decoder_top.sv
// ----------------------------------------------------------------------------
// ntfs_runlist_decoder_top: NTFS data-run list decoder
// Parses run-list bytes into runs and gives for each run its length, start
// cluster and start sector, plus end-of-list and bad-header results.
// ----------------------------------------------------------------------------
//  Channel      Direction  Handshake     Payload
//  list_bytes   in         valid/ready   run_byte, list_start
//  results      out        valid/ready   result_kind, run_clusters,
//                                        start_cluster, start_sector, list_done
//  cfg          in         cfg_we        cfg_index, cfg_data
//
//  One byte is taken every cycle while the job queue has room.
//  After the byte that completes it, a result passes through the queue, the
//  multiplier stage and the output register, in that order.
//  A stalled result side fills the queue of QUEUE_DEPTH jobs before the byte
//  side stalls. Reset is synchronous and empties the queue and both stages;
//  no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ntfs_runlist_decoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  nrld_byte_if.sink         list_bytes,
  nrld_result_if.source     results,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [31:0]    hidden_sectors;
  logic [7:0]     sectors_per_cluster;

  nrld_pkg::job_t front_job;
  logic           front_push;
  logic           queue_space;
  logic           queue_valid;
  nrld_pkg::job_t queue_job;
  logic           back_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hidden_sectors      <= 32'd0;
      sectors_per_cluster <= nrld_pkg::SPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nrld_pkg::CFG_HIDDEN_SECTORS:      hidden_sectors      <= cfg_data;
        nrld_pkg::CFG_SECTORS_PER_CLUSTER: sectors_per_cluster <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  nrld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .list_bytes (list_bytes),
    .job        (front_job),
    .job_push   (front_push),
    .job_space  (queue_space)
  );

  nrld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_push),
    .push_job  (front_job),
    .space     (queue_space),
    .pop_valid (queue_valid),
    .pop_job   (queue_job),
    .pop_ready (back_ready)
  );

  nrld_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .job_valid           (queue_valid),
    .job                 (queue_job),
    .job_ready           (back_ready),
    .hidden_sectors      (hidden_sectors),
    .sectors_per_cluster (sectors_per_cluster),
    .results             (results)
  );

endmodule

`default_nettype wire

>>> src/nrld_checker.sv
// ----------------------------------------------------------------------------
// nrld_checker: port checks for the run-list decoder
// Watches the result channel of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module nrld_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic [1:0]  result_kind,
  input  wire logic [31:0] run_clusters,
  input  wire logic [63:0] start_cluster,
  input  wire logic [63:0] start_sector,
  input  wire logic        list_done
);

  // Nothing is offered in the cycle after reset.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result offered straight after reset");

  assert property (@(posedge clk) disable iff (rst)
    res_valid |->
      (list_done == (result_kind != nrld_pkg::KIND_RUN)))
    else $error("list_done does not match the result kind");

  // End and error results carry no run information.
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && list_done) |->
      (run_clusters == 32'd0 && start_cluster == 64'd0 &&
       start_sector == 64'd0))
    else $error("end or error result with nonzero address fields");

  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      (res_valid && $stable(start_sector) && $stable(result_kind)))
    else $error("stalled result changed or vanished");

endmodule

bind ntfs_runlist_decoder_top nrld_checker u_nrld_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (results.valid),
  .res_ready     (results.ready),
  .result_kind   (results.result_kind),
  .run_clusters  (results.run_clusters),
  .start_cluster (results.start_cluster),
  .start_sector  (results.start_sector),
  .list_done     (results.list_done)
);

`default_nettype wire

>>> tb/ntfs_runlist_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntfs_runlist_decoder_top_tb: self-checking bench for the run-list decoder
// A directed list walk, then random run lists under several volume settings.
// Each result is checked against a bit-accurate decoder model kept here.
// ----------------------------------------------------------------------------

module ntfs_runlist_decoder_top_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_ITEMS   = 200;
  localparam int NUM_PHASES    = 5;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET
  } parse_phase_t;

  typedef struct packed {
    nrld_pkg::result_kind_t kind;
    logic [31:0]            run_clusters;
    logic [63:0]            start_cluster;
    logic [63:0]            start_sector;
    logic                   list_done;
  } run_result_t;

  typedef struct {
    logic [7:0]  run_byte;
    logic        list_start;
    bit          typed;
    run_result_t want;
  } list_row_t;

  localparam run_result_t NO_RESULT = '0;
  localparam run_result_t LIST_END_RESULT = {nrld_pkg::KIND_END, 32'h0, 64'h0, 64'h0, 1'b1};
  localparam run_result_t BAD_HEADER_RESULT = {nrld_pkg::KIND_BAD, 32'h0, 64'h0, 64'h0,
                                               1'b1};
  // One-byte length 0xff, one-byte offset -128, default eight sectors per cluster.
  localparam run_result_t NEG_SHORT_RUN = {nrld_pkg::KIND_RUN, 32'h0000_00ff,
                                           64'hffff_ffff_ffff_ff80,
                                           64'hffff_ffff_ffff_fc00, 1'b0};

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  nrld_byte_if   byte_ch();
  nrld_result_if result_ch();

  ntfs_runlist_decoder_top u_top (
    .clk        (clk),
    .rst        (rst),
    .list_bytes (byte_ch),
    .results    (result_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Decoder model state and its copy of the registers.
  parse_phase_t model_phase;
  logic [2:0]   len_count;
  logic [2:0]   off_count;
  logic [2:0]   byte_pos;
  logic [31:0]  len_acc;
  logic [31:0]  off_acc;
  logic [63:0]  cluster_sum;
  logic [31:0]  hidden_sectors;
  logic [7:0]   sectors_per_cluster;

  run_result_t runs_due[$];
  int          err_count;
  int          live_items;
  int          cycle_count;
  bit          calm;
  bit          hold_request;

  list_row_t directed_rows [26] = '{
    '{8'h00, 1'b0, 1'b0, NO_RESULT},          // idle after reset: ignored
    '{8'h00, 1'b1, 1'b1, LIST_END_RESULT},    // empty list
    '{8'h37, 1'b0, 1'b0, NO_RESULT},          // idle again: ignored
    '{8'h05, 1'b1, 1'b1, BAD_HEADER_RESULT},  // length count too large
    '{8'h50, 1'b1, 1'b1, BAD_HEADER_RESULT},  // no length bytes
    '{8'hff, 1'b1, 1'b1, BAD_HEADER_RESULT},
    '{8'h11, 1'b1, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b1, NEG_SHORT_RUN},
    '{8'h44, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h80, 1'b0, 1'b0, NO_RESULT},
    '{8'h32, 1'b0, 1'b0, NO_RESULT},
    '{8'h34, 1'b0, 1'b0, NO_RESULT},
    '{8'h12, 1'b0, 1'b0, NO_RESULT},
    '{8'h21, 1'b1, 1'b0, NO_RESULT},          // new list cuts the run short
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'h7f, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b1, LIST_END_RESULT}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return 8'($urandom());
  endfunction

  function automatic void reset_model();
    model_phase         = PH_IDLE;
    len_count           = '0;
    off_count           = '0;
    byte_pos            = '0;
    len_acc             = '0;
    off_acc             = '0;
    cluster_sum         = '0;
    hidden_sectors      = '0;
    sectors_per_cluster = nrld_pkg::SPC_RESET;
  endfunction

  // Advances the model by one byte; returns 1 when the byte yields a result.
  function automatic bit decode_run_byte(input logic [7:0] b, input logic first,
                                         output run_result_t res);
    logic [3:0]         lc;
    logic [3:0]         oc;
    logic signed [63:0] offset;
    int                 sh;
    res = NO_RESULT;
    decode_run_byte = 1'b0;
    if (first) begin
      cluster_sum = '0;
      model_phase = PH_HEADER;
    end
    case (model_phase)
      PH_HEADER: begin
        lc = b[3:0];
        oc = b[7:4];
        if (b == 8'h00) begin
          model_phase = PH_IDLE;
          res = LIST_END_RESULT;
          decode_run_byte = 1'b1;
        end else if (lc == 0 || lc > 4 || oc == 0 || oc > 4) begin
          model_phase = PH_IDLE;
          res = BAD_HEADER_RESULT;
          decode_run_byte = 1'b1;
        end else begin
          len_count   = lc[2:0];
          off_count   = oc[2:0];
          byte_pos    = '0;
          len_acc     = '0;
          off_acc     = '0;
          model_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc  = len_acc | (32'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        if (byte_pos >= len_count) begin
          byte_pos    = '0;
          model_phase = PH_OFFSET;
        end
      end
      PH_OFFSET: begin
        off_acc  = off_acc | (32'(b) << (8 * byte_pos));
        byte_pos = byte_pos + 3'd1;
        if (byte_pos >= off_count) begin
          // The sign bit is the top bit of the last offset byte received.
          sh          = 64 - 8 * int'(off_count);
          offset      = {32'h0, off_acc} << sh;
          offset      = offset >>> sh;
          cluster_sum = cluster_sum + offset;
          res.kind          = nrld_pkg::KIND_RUN;
          res.run_clusters  = len_acc;
          res.start_cluster = cluster_sum;
          res.start_sector  = 64'(hidden_sectors) + cluster_sum * 64'(sectors_per_cluster);
          byte_pos    = '0;
          model_phase = PH_HEADER;
          decode_run_byte = 1'b1;
        end
      end
      default: model_phase = PH_IDLE;
    endcase
  endfunction

  // Offers one byte and returns at the edge where it is taken.
  task automatic send_byte(input logic [7:0] b, input logic first,
                           input bit typed = 1'b0, input run_result_t want = NO_RESULT);
    int          gap;
    run_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      byte_ch.valid = 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    byte_ch.valid      = 1'b1;
    byte_ch.run_byte   = b;
    byte_ch.list_start = first;
    do @(posedge clk); while (!byte_ch.ready);
    if (first || model_phase != PH_IDLE) live_items++;
    if (decode_run_byte(b, first, res)) runs_due.push_back(typed ? want : res);
  endtask

  task automatic send_list();
    int         runs;
    int         ending;
    int         cut;
    logic       first;
    logic [3:0] lc;
    logic [3:0] oc;
    logic [7:0] hdr;
    runs   = $urandom_range(0, 6);
    ending = $urandom_range(0, 9);
    first  = 1'b1;
    for (int r = 0; r < runs; r++) begin
      lc = 4'($urandom_range(1, 4));
      oc = 4'($urandom_range(1, 4));
      send_byte({oc, lc}, first);
      first = 1'b0;
      for (int k = 0; k < lc + oc; k++) send_byte(pick_byte(), 1'b0);
    end
    if (ending < 6) begin
      send_byte(8'h00, first);
    end else if (ending < 8) begin
      do hdr = 8'($urandom_range(1, 255));
      while (hdr[3:0] inside {[1:4]} && hdr[7:4] inside {[1:4]});
      send_byte(hdr, first);
    end else begin
      // Leave a run unfinished; the next list start has to drop it.
      lc  = 4'($urandom_range(1, 4));
      oc  = 4'($urandom_range(1, 4));
      cut = $urandom_range(0, lc + oc - 1);
      send_byte({oc, lc}, first);
      for (int k = 0; k < cut; k++) send_byte(pick_byte(), 1'b0);
    end
  endtask

  // Stops offering bytes and waits until the block has nothing left in flight.
  task automatic drain();
    @(negedge clk);
    byte_ch.valid = 1'b0;
    while (runs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    if (idx == nrld_pkg::CFG_HIDDEN_SECTORS) hidden_sectors = data;
    else sectors_per_cluster = data[7:0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    err_count++;
    if (err_count <= REPORT_LIMIT)
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
  endtask

  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (rst) begin
        result_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        result_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        result_ch.ready = 1'b0;
        stall_left--;
      end else begin
        result_ch.ready = 1'b1;
        if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    run_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (runs_due.size() == 0) begin
        err_count++;
        if (err_count <= REPORT_LIMIT)
          $display("%0t: result of kind %0d with no request outstanding",
                   $realtime, result_ch.result_kind);
      end else begin
        want = runs_due.pop_front();
        if (result_ch.result_kind !== want.kind)
          note_mismatch("result_kind", 64'(want.kind), 64'(result_ch.result_kind));
        if (result_ch.run_clusters !== want.run_clusters)
          note_mismatch("run_clusters", 64'(want.run_clusters), 64'(result_ch.run_clusters));
        if (result_ch.start_cluster !== want.start_cluster)
          note_mismatch("start_cluster", want.start_cluster, result_ch.start_cluster);
        if (result_ch.start_sector !== want.start_sector)
          note_mismatch("start_sector", want.start_sector, result_ch.start_sector);
        if (result_ch.list_done !== want.list_done)
          note_mismatch("list_done", 64'(want.list_done), 64'(result_ch.list_done));
      end
    end
  end

  initial begin : stimulus
    int target;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = nrld_pkg::CFG_HIDDEN_SECTORS;
    cfg_data           = '0;
    byte_ch.valid      = 1'b0;
    byte_ch.run_byte   = '0;
    byte_ch.list_start = 1'b0;
    err_count    = 0;
    live_items   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    reset_model();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].run_byte, directed_rows[i].list_start,
                directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          write_reg(nrld_pkg::CFG_HIDDEN_SECTORS, 32'hffff_ffff);
          write_reg(nrld_pkg::CFG_SECTORS_PER_CLUSTER, {24'($urandom()), 8'd128});
        end
        1: begin
          write_reg(nrld_pkg::CFG_HIDDEN_SECTORS, $urandom());
          write_reg(nrld_pkg::CFG_SECTORS_PER_CLUSTER, {24'($urandom()), 8'd1});
        end
        2: begin
          write_reg(nrld_pkg::CFG_HIDDEN_SECTORS, 32'h0);
          write_reg(nrld_pkg::CFG_SECTORS_PER_CLUSTER, {24'($urandom()), 8'd0});
        end
        3: begin
          write_reg(nrld_pkg::CFG_HIDDEN_SECTORS, $urandom());
          write_reg(nrld_pkg::CFG_SECTORS_PER_CLUSTER, {24'($urandom()), 8'd255});
        end
        default: begin
          write_reg(nrld_pkg::CFG_HIDDEN_SECTORS, $urandom());
          write_reg(nrld_pkg::CFG_SECTORS_PER_CLUSTER,
                    {24'($urandom()), 8'($urandom_range(1, 128))});
        end
      endcase
      // The third setting runs with no gaps on either side.
      calm = (p == 2);
      // Hold results back long enough for the job queue to fill up.
      if (p == 1) hold_request = 1'b1;
      target = live_items + PHASE_ITEMS;
      while (live_items < target) begin
        if ($urandom_range(0, 9) == 0)
          send_byte(8'($urandom()), $urandom_range(0, 9) == 0);
        else
          send_list();
      end
      drain();
    end

    if (err_count == 0 && runs_due.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
